@@ rtl/core/lorenz_euler_point_generator_defines.svh @@
// Assertion macros used by the point generator core.
`ifndef LORENZ_EULER_POINT_GENERATOR_DEFINES_SVH
`define LORENZ_EULER_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LEPG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LEPG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

@@ rtl/core/lepg_pkg.sv @@
// Types, constants and step program for the Lorenz point generator.
package lepg_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 24;
    localparam int WIDE_W    = 2 * WORD_W;
    localparam int COEF_W    = 31;
    localparam int DT_W      = 25;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RHO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BETA    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd6;

    // Reset values, Q8.24
    localparam logic [COEF_W-1:0] SIGMA_RST = 31'd167772160;
    localparam logic [COEF_W-1:0] RHO_RST   = 31'd469762048;
    localparam logic [COEF_W-1:0] BETA_RST  = 31'd44739243;
    localparam logic [DT_W-1:0]   DT_RST    = 25'd167772;
    localparam word_t             POINT_RST = 32'sd167772160;

    // Shared unit operations
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;

    // Operand sources
    localparam logic [3:0] SRC_X    = 4'd0;
    localparam logic [3:0] SRC_Y    = 4'd1;
    localparam logic [3:0] SRC_Z    = 4'd2;
    localparam logic [3:0] SRC_T0   = 4'd3;
    localparam logic [3:0] SRC_T1   = 4'd4;
    localparam logic [3:0] SRC_SIG  = 4'd5;
    localparam logic [3:0] SRC_RHO  = 4'd6;
    localparam logic [3:0] SRC_BETA = 4'd7;
    localparam logic [3:0] SRC_DT   = 4'd8;

    // Destinations
    localparam logic [2:0] DST_X  = 3'd0;
    localparam logic [2:0] DST_Y  = 3'd1;
    localparam logic [2:0] DST_Z  = 3'd2;
    localparam logic [2:0] DST_T0 = 3'd3;
    localparam logic [2:0] DST_T1 = 3'd4;

    localparam int PC_W     = 4;
    localparam int PROG_LEN = 14;
    localparam logic [PC_W-1:0] LAST_PC = PC_W'(PROG_LEN - 1);

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] src_a;
        logic [3:0] src_b;
        logic [2:0] dst;
    } uop_t;

    typedef struct packed {
        logic [1:0] op;
        word_t      a;
        word_t      b;
    } alu_req_t;

    typedef struct packed {
        word_t value;
        logic  sat;
    } alu_rsp_t;

    typedef struct packed {
        logic [COEF_W-1:0] sigma;
        logic [COEF_W-1:0] rho;
        logic [COEF_W-1:0] beta;
        logic [DT_W-1:0]   time_step;
        word_t             start_x;
        word_t             start_y;
        word_t             start_z;
    } cfg_t;

    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t pos_z;
        logic  overflow;
    } point_t;

    // One Euler step: x first, then y from new x, then z from new x and y
    function automatic uop_t step_uop(input logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            4'd0:    u = '{OP_SUB, SRC_Y,    SRC_X,  DST_T0};
            4'd1:    u = '{OP_MUL, SRC_SIG,  SRC_T0, DST_T0};
            4'd2:    u = '{OP_MUL, SRC_T0,   SRC_DT, DST_T0};
            4'd3:    u = '{OP_ADD, SRC_X,    SRC_T0, DST_X};
            4'd4:    u = '{OP_SUB, SRC_RHO,  SRC_Z,  DST_T0};
            4'd5:    u = '{OP_MUL, SRC_X,    SRC_T0, DST_T0};
            4'd6:    u = '{OP_SUB, SRC_T0,   SRC_Y,  DST_T0};
            4'd7:    u = '{OP_MUL, SRC_T0,   SRC_DT, DST_T0};
            4'd8:    u = '{OP_ADD, SRC_Y,    SRC_T0, DST_Y};
            4'd9:    u = '{OP_MUL, SRC_X,    SRC_Y,  DST_T0};
            4'd10:   u = '{OP_MUL, SRC_BETA, SRC_Z,  DST_T1};
            4'd11:   u = '{OP_SUB, SRC_T0,   SRC_T1, DST_T0};
            4'd12:   u = '{OP_MUL, SRC_T0,   SRC_DT, DST_T0};
            4'd13:   u = '{OP_ADD, SRC_Z,    SRC_T0, DST_Z};
            default: u = '{OP_ADD, SRC_X,    SRC_X,  DST_T1};
        endcase
        return u;
    endfunction

endpackage

@@ rtl/core/lepg_alu.sv @@
// Shared saturating add, subtract and fixed-point multiply unit.
module lepg_alu
    import lepg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    wide_t      wide_reg;
    wide_t      wide_next;
    logic [1:0] op_reg;
    wide_t      shifted;
    logic [WIDE_W-WORD_W:0] upper;
    logic       in_range;

    // Full-width result, registered before the shift and clamp
    always_comb
    begin
        case (req.op)
            OP_ADD:  wide_next = WIDE_W'(req.a) + WIDE_W'(req.b);
            OP_SUB:  wide_next = WIDE_W'(req.a) - WIDE_W'(req.b);
            OP_MUL:  wide_next = WIDE_W'(req.a) * WIDE_W'(req.b);
            default: wide_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= OP_ADD;
        end
        else
        begin
            op_reg <= req.op;
        end
    end

    always_ff @(posedge clk)
    begin
        wide_reg <= wide_next;
    end

    // Arithmetic shift floors the product; then clamp to the word range
    always_comb
    begin
        shifted  = (op_reg == OP_MUL) ? (wide_reg >>> FRAC_BITS) : wide_reg;
        upper    = shifted[WIDE_W-1:WORD_W-1];
        in_range = (&upper) | ~(|upper);
        rsp.sat  = ~in_range;
        if (in_range)
        begin
            rsp.value = shifted[WORD_W-1:0];
        end
        else
        begin
            rsp.value = shifted[WIDE_W-1] ? WORD_MIN : WORD_MAX;
        end
    end

endmodule

@@ rtl/core/lepg_core.sv @@
// Step sequencer and coordinate register file around the shared arithmetic unit.
`include "lorenz_euler_point_generator_defines.svh"

module lepg_core
    import lepg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    input  logic   in_restart,
    output logic   in_ready,
    output logic   res_valid,
    input  logic   res_take,
    output point_t res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            phase_reg, phase_next;
    word_t           x_reg, y_reg, z_reg;
    word_t           t0_reg, t1_reg;
    word_t           px_reg, py_reg, pz_reg;
    logic            ovf_reg;

    uop_t     uop;
    alu_req_t req;
    alu_rsp_t rsp;
    logic     accept;
    logic     wr_en;

    function automatic word_t pick(input logic [3:0] src, input word_t x, input word_t y,
                                   input word_t z, input word_t t0, input word_t t1,
                                   input cfg_t c);
        word_t v;
        case (src)
            SRC_X:    v = x;
            SRC_Y:    v = y;
            SRC_Z:    v = z;
            SRC_T0:   v = t0;
            SRC_T1:   v = t1;
            SRC_SIG:  v = WORD_W'(c.sigma);
            SRC_RHO:  v = WORD_W'(c.rho);
            SRC_BETA: v = WORD_W'(c.beta);
            SRC_DT:   v = WORD_W'(c.time_step);
            default:  v = '0;
        endcase
        return v;
    endfunction

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = '{px_reg, py_reg, pz_reg, ovf_reg};
    assign wr_en     = (state_reg == ST_RUN) && phase_reg;

    always_comb
    begin
        uop     = step_uop(pc_reg);
        req.op  = uop.op;
        req.a   = pick(uop.src_a, x_reg, y_reg, z_reg, t0_reg, t1_reg, cfg);
        req.b   = pick(uop.src_b, x_reg, y_reg, z_reg, t0_reg, t1_reg, cfg);
    end

    lepg_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                    phase_next = 1'b0;
                end
            end
            ST_RUN:
            begin
                phase_next = ~phase_reg;
                if (phase_reg)
                begin
                    if (pc_reg == LAST_PC)
                    begin
                        state_next = ST_DONE;
                        pc_next    = '0;
                    end
                    else
                    begin
                        pc_next = pc_reg + PC_W'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                pc_next    = '0;
                phase_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            phase_reg <= 1'b0;
            x_reg     <= POINT_RST;
            y_reg     <= POINT_RST;
            z_reg     <= POINT_RST;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            phase_reg <= phase_next;
            if (accept)
            begin
                ovf_reg <= 1'b0;
                if (in_restart)
                begin
                    x_reg <= cfg.start_x;
                    y_reg <= cfg.start_y;
                    z_reg <= cfg.start_z;
                end
            end
            else if (wr_en)
            begin
                ovf_reg <= ovf_reg | rsp.sat;
                case (uop.dst)
                    DST_X:   x_reg <= rsp.value;
                    DST_Y:   y_reg <= rsp.value;
                    DST_Z:   z_reg <= rsp.value;
                    default: ;
                endcase
            end
        end
    end

    // Temporaries and the emitted point snapshot
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= in_restart ? cfg.start_x : x_reg;
            py_reg <= in_restart ? cfg.start_y : y_reg;
            pz_reg <= in_restart ? cfg.start_z : z_reg;
        end
        if (wr_en && (uop.dst == DST_T0))
        begin
            t0_reg <= rsp.value;
        end
        if (wr_en && (uop.dst == DST_T1))
        begin
            t1_reg <= rsp.value;
        end
    end

    `LEPG_ASSERT_NXT(a_start_run, clk, rst_n, accept, (state_reg == ST_RUN) && (pc_reg == '0) && !phase_reg)
    `LEPG_ASSERT_NXT(a_last_done, clk, rst_n, wr_en && (pc_reg == LAST_PC), state_reg == ST_DONE)
    `LEPG_ASSERT_IMP(a_idle_pc, clk, rst_n, state_reg != ST_RUN, (pc_reg == '0) && !phase_reg)
    `LEPG_ASSERT_NXT(a_hold_res, clk, rst_n, res_valid && !res_take, res_valid && $stable(res))

endmodule

@@ rtl/core/lorenz_euler_point_generator.sv @@
// Top level of the Lorenz point generator: configuration registers, item ports, output register.
// Each accepted input item runs 14 operations on the one shared add/subtract/multiply unit,
//   then is handed off into the output register.
// The step sequencer takes no new item until the current one has been handed off.
// A result waiting in the output register does not block the next item from being accepted.
// Reset (rst_n low, asynchronous): registers return to their defaults, point to (10, 10, 10).
module lorenz_euler_point_generator
    import lepg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [0] restart, [7:1] zero
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
    output logic [0:0]           m_tuser    // [0] overflow
);

    cfg_t   cfg_reg;
    point_t res;
    point_t out_reg;
    logic   res_valid;
    logic   res_take;
    logic   m_valid_reg;

    // Configuration writes are always taken; drop unknown indexes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sigma     <= SIGMA_RST;
            cfg_reg.rho       <= RHO_RST;
            cfg_reg.beta      <= BETA_RST;
            cfg_reg.time_step <= DT_RST;
            cfg_reg.start_x   <= POINT_RST;
            cfg_reg.start_y   <= POINT_RST;
            cfg_reg.start_z   <= POINT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SIGMA:   cfg_reg.sigma     <= cfg_data[COEF_W-1:0];
                REG_RHO:     cfg_reg.rho       <= cfg_data[COEF_W-1:0];
                REG_BETA:    cfg_reg.beta      <= cfg_data[COEF_W-1:0];
                REG_DT:      cfg_reg.time_step <= cfg_data[DT_W-1:0];
                REG_START_X: cfg_reg.start_x   <= cfg_data;
                REG_START_Y: cfg_reg.start_y   <= cfg_data;
                REG_START_Z: cfg_reg.start_z   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Sequencer plus shared unit: takes one item, hands back the point and its overflow flag
    lepg_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_restart (s_tdata[0]),
        .in_ready   (s_tready),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    // Advance the finished item into the output register once it is free or being drained
    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // Hold the payload while the item waits downstream
    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.pos_z, out_reg.pos_y, out_reg.pos_x};
    assign m_tuser  = out_reg.overflow;

endmodule
